// ===== design/ldpq_pkg.sv =====
`timescale 1ns / 1ps
package ldpq_pkg;

  localparam int HEAP_DEPTH_DEF    = 64;
  localparam int PENDING_SLOTS_DEF = 16;
  localparam int VAL_W             = 32;
  localparam int CNT_W             = 7;
  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

  localparam logic [1:0] FN_PUSH   = 2'd0;
  localparam logic [1:0] FN_POP    = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;

  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_HEAP_FULL   = 3'd1;
  localparam logic [2:0] STS_PEND_FULL   = 3'd2;
  localparam logic [2:0] STS_REMOVE_ZERO = 3'd3;
  localparam logic [2:0] STS_POP_EMPTY   = 3'd4;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] top_value;
    logic                    top_valid;
    logic [CNT_W-1:0]        live_count;
    logic [2:0]              status;
  } out_item_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_INC,
    PEND_DEC
  } pend_op_t;

  typedef struct packed {
    pend_op_t         op;
    logic [VAL_W-1:0] key;
  } pend_cmd_t;

  typedef struct packed {
    logic hit;
    logic can_inc;
  } pend_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CLEAN_A,
    S_CLEAN_B,
    S_DROP,
    S_DROP_LD,
    S_SD_RDL,
    S_SD_RDR,
    S_SD_CMP,
    S_SU_CHK,
    S_SU_CMP,
    S_REB_NEXT,
    S_REB_LD,
    S_RESP
  } state_t;

  // true when a belongs above b in the current order
  function automatic logic above(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                                 input logic mode);
    if (mode) begin
      return $signed(a) < $signed(b);
    end else begin
      return $signed(a) > $signed(b);
    end
  endfunction

endpackage

// ===== design/ldpq_heap_ram.sv =====
`timescale 1ns / 1ps
module ldpq_heap_ram import ldpq_pkg::*; #(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
  localparam int AW = $clog2(HEAP_DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [VAL_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem [HEAP_DEPTH];
  logic [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ldpq_pend_tbl.sv =====
`timescale 1ns / 1ps
module ldpq_pend_tbl import ldpq_pkg::*; #(
  parameter int PENDING_SLOTS = PENDING_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pend_cmd_t  cmd,
  output pend_stat_t stat
);

  logic [VAL_W-1:0]         val_r [PENDING_SLOTS];
  logic [CNT_W-1:0]         cnt_r [PENDING_SLOTS];
  logic [PENDING_SLOTS-1:0] match;
  logic [PENDING_SLOTS-1:0] free_oh;
  logic [PENDING_SLOTS-1:0] sel_oh;
  logic                     any_free;
  logic                     hit_sat;

  always_comb begin
    any_free = 1'b0;
    hit_sat  = 1'b0;
    for (int k = 0; k < PENDING_SLOTS; k++) begin
      match[k]   = (cnt_r[k] != '0) && (val_r[k] == cmd.key);
      free_oh[k] = (cnt_r[k] == '0) && !any_free;
      if (cnt_r[k] == '0) begin
        any_free = 1'b1;
      end
      if (match[k] && cnt_r[k] >= COUNT_MAX) begin
        hit_sat = 1'b1;
      end
    end
  end

  // live values are unique in the table, so at most one slot matches
  assign stat.hit     = |match;
  assign stat.can_inc = stat.hit ? !hit_sat : any_free;
  assign sel_oh       = stat.hit ? match : free_oh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PENDING_SLOTS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < PENDING_SLOTS; k++) begin
        if (cmd.op == PEND_INC && sel_oh[k]) begin
          cnt_r[k] <= cnt_r[k] + CNT_W'(1);
        end else if (cmd.op == PEND_DEC && match[k]) begin
          cnt_r[k] <= cnt_r[k] - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PENDING_SLOTS; k++) begin
      if (cmd.op == PEND_INC && sel_oh[k]) begin
        val_r[k] <= cmd.key;
      end
    end
  end

endmodule

// ===== design/ldpq_ctrl.sv =====
`timescale 1ns / 1ps
module ldpq_ctrl import ldpq_pkg::*; #(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
  localparam int AW = $clog2(HEAP_DEPTH),
  localparam int FW = $clog2(HEAP_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             order_mode,
  input  logic             cfg_we,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  input  logic             out_free,
  output logic             resp_valid,
  output out_item_t        resp,
  output logic             ram_wr_en,
  output logic [AW-1:0]    ram_wr_addr,
  output logic [VAL_W-1:0] ram_wr_data,
  output logic             ram_rd_en,
  output logic [AW-1:0]    ram_rd_addr,
  input  logic [VAL_W-1:0] ram_rd_data,
  output pend_cmd_t        pend_cmd,
  input  pend_stat_t       pend_stat
);

  localparam int CW = AW + 2;
  localparam int LW = (FW > CNT_W) ? FW : CNT_W;

  state_t           state_r, state_nxt;
  state_t           ret_r, ret_nxt;
  in_item_t         item_r, item_nxt;
  logic [2:0]       status_r, status_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [FW-1:0]    live_r, live_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    reb_k_r, reb_k_nxt;
  logic [VAL_W-1:0] cur_r, cur_nxt;
  logic [VAL_W-1:0] lval_r, lval_nxt;
  logic             has_rc_r, has_rc_nxt;
  logic [VAL_W-1:0] top_r;

  logic [CW-1:0]    l_idx, r_idx, fill_ext;
  logic             l_in, r_in;
  logic [AW-1:0]    p_idx;
  logic [FW-1:0]    fill_m1, fill_half;
  logic             full, empty_pop, clean_hit;
  logic             l_bet, r_bet, move, up;
  logic [VAL_W-1:0] best_v, mv_val;
  logic [AW-1:0]    mv_idx;
  logic [LW-1:0]    live_ext;

  assign l_idx     = {1'b0, idx_r, 1'b1};
  assign r_idx     = l_idx + CW'(1);
  assign fill_ext  = CW'(fill_r);
  assign l_in      = l_idx < fill_ext;
  assign r_in      = r_idx < fill_ext;
  assign p_idx     = (idx_r - AW'(1)) >> 1;
  assign fill_m1   = fill_r - FW'(1);
  assign fill_half = fill_r >> 1;
  assign full      = fill_r >= FW'(HEAP_DEPTH);
  assign empty_pop = (fill_r == '0) || (live_r == '0);
  assign clean_hit = (fill_r != '0) && pend_stat.hit;

  assign l_bet  = above(lval_r, cur_r, order_mode);
  assign best_v = l_bet ? lval_r : cur_r;
  assign r_bet  = has_rc_r && above(ram_rd_data, best_v, order_mode);
  assign move   = l_bet || r_bet;
  assign mv_val = r_bet ? ram_rd_data : lval_r;
  assign mv_idx = r_bet ? r_idx[AW-1:0] : l_idx[AW-1:0];
  assign up     = above(cur_r, ram_rd_data, order_mode);

  assign in_ready     = (state_r == S_IDLE) && !cfg_we;

  assign live_ext        = LW'(live_r);
  assign resp.top_value  = (fill_r != '0) ? top_r : '0;
  assign resp.top_valid  = fill_r != '0;
  assign resp.live_count = (live_ext > LW'(COUNT_MAX)) ? COUNT_MAX : live_ext[CNT_W-1:0];
  assign resp.status     = status_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          state_nxt = S_REB_NEXT;
        end else if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (item_r.func)
          FN_PUSH:   state_nxt = full ? S_RESP : S_SU_CHK;
          FN_POP:    state_nxt = S_CLEAN_A;
          FN_REMOVE: state_nxt = (live_r == '0 || !pend_stat.can_inc) ? S_RESP : S_CLEAN_B;
          default:   state_nxt = S_RESP;
        endcase
      end
      S_CLEAN_A:  state_nxt = (clean_hit || !empty_pop) ? S_DROP : S_RESP;
      S_CLEAN_B:  state_nxt = clean_hit ? S_DROP : S_RESP;
      S_DROP:     state_nxt = (fill_r == FW'(1)) ? ret_r : S_DROP_LD;
      S_DROP_LD:  state_nxt = S_SD_RDL;
      S_SD_RDL:   state_nxt = l_in ? S_SD_RDR : ret_r;
      S_SD_RDR:   state_nxt = S_SD_CMP;
      S_SD_CMP:   state_nxt = move ? S_SD_RDL : ret_r;
      S_SU_CHK:   state_nxt = (idx_r == '0) ? ret_r : S_SU_CMP;
      S_SU_CMP:   state_nxt = up ? S_SU_CHK : ret_r;
      S_REB_NEXT: state_nxt = (reb_k_r == '0) ? S_IDLE : S_REB_LD;
      S_REB_LD:   state_nxt = S_SD_RDL;
      S_RESP:     state_nxt = out_free ? S_IDLE : S_RESP;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ret_nxt      = ret_r;
    item_nxt     = item_r;
    status_nxt   = status_r;
    fill_nxt     = fill_r;
    live_nxt     = live_r;
    idx_nxt      = idx_r;
    reb_k_nxt    = reb_k_r;
    cur_nxt      = cur_r;
    lval_nxt     = lval_r;
    has_rc_nxt   = has_rc_r;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = idx_r;
    ram_wr_data  = cur_r;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = l_idx[AW-1:0];
    pend_cmd.op  = PEND_NONE;
    pend_cmd.key = (state_r == S_EXEC) ? item_r.value : top_r;
    resp_valid   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          reb_k_nxt = fill_half[AW-1:0];
        end else if (in_valid) begin
          item_nxt   = in_item;
          status_nxt = STS_OK;
        end
      end
      S_EXEC: begin
        unique case (item_r.func)
          FN_PUSH: begin
            if (full) begin
              status_nxt = STS_HEAP_FULL;
            end else begin
              idx_nxt  = fill_r[AW-1:0];
              cur_nxt  = item_r.value;
              fill_nxt = fill_r + FW'(1);
              live_nxt = live_r + FW'(1);
              ret_nxt  = S_RESP;
            end
          end
          FN_REMOVE: begin
            if (live_r == '0) begin
              status_nxt = STS_REMOVE_ZERO;
            end else if (!pend_stat.can_inc) begin
              status_nxt = STS_PEND_FULL;
            end else begin
              pend_cmd.op = PEND_INC;
              live_nxt    = live_r - FW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_CLEAN_A: begin
        if (clean_hit) begin
          pend_cmd.op = PEND_DEC;
          ret_nxt     = S_CLEAN_A;
        end else if (empty_pop) begin
          status_nxt = STS_POP_EMPTY;
        end else begin
          live_nxt = live_r - FW'(1);
          ret_nxt  = S_CLEAN_B;
        end
      end
      S_CLEAN_B: begin
        if (clean_hit) begin
          pend_cmd.op = PEND_DEC;
          ret_nxt     = S_CLEAN_B;
        end
      end
      S_DROP: begin
        // last entry moves to the root, then sifts down
        fill_nxt    = fill_m1;
        ram_rd_addr = fill_m1[AW-1:0];
        ram_rd_en   = fill_r != FW'(1);
      end
      S_DROP_LD: begin
        cur_nxt = ram_rd_data;
        idx_nxt = '0;
      end
      S_SD_RDL: begin
        if (l_in) begin
          ram_rd_en = 1'b1;
        end else begin
          ram_wr_en = 1'b1;
        end
      end
      S_SD_RDR: begin
        lval_nxt    = ram_rd_data;
        has_rc_nxt  = r_in;
        ram_rd_en   = r_in;
        ram_rd_addr = r_idx[AW-1:0];
      end
      S_SD_CMP: begin
        ram_wr_en = 1'b1;
        if (move) begin
          ram_wr_data = mv_val;
          idx_nxt     = mv_idx;
        end
      end
      S_SU_CHK: begin
        if (idx_r == '0) begin
          ram_wr_en = 1'b1;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = p_idx;
        end
      end
      S_SU_CMP: begin
        ram_wr_en = 1'b1;
        if (up) begin
          ram_wr_data = ram_rd_data;
          idx_nxt     = p_idx;
        end
      end
      S_REB_NEXT: begin
        if (reb_k_r != '0) begin
          reb_k_nxt   = reb_k_r - AW'(1);
          idx_nxt     = reb_k_r - AW'(1);
          ram_rd_en   = 1'b1;
          ram_rd_addr = reb_k_r - AW'(1);
        end
      end
      S_REB_LD: begin
        cur_nxt = ram_rd_data;
        ret_nxt = S_REB_NEXT;
      end
      S_RESP: begin
        resp_valid = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_RESP;
      fill_r  <= '0;
      live_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      fill_r  <= fill_nxt;
      live_r  <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    reb_k_r  <= reb_k_nxt;
    cur_r    <= cur_nxt;
    lval_r   <= lval_nxt;
    has_rc_r <= has_rc_nxt;
    // shadow of the root entry
    if (ram_wr_en && ram_wr_addr == '0) begin
      top_r <= ram_wr_data;
    end
  end

`ifndef SYNTHESIS
  a_live_le_fill: assert property (@(posedge clk) disable iff (!rst_n) live_r <= fill_r)
    else $error("live count exceeds heap fill");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(HEAP_DEPTH))
    else $error("heap fill beyond depth");
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n) !(ram_wr_en && ram_rd_en))
    else $error("heap read and write in the same cycle");
`endif

endmodule

// ===== design/lazy_deletion_priority_queue.sv =====
`timescale 1ns / 1ps
// Priority queue of signed 32-bit values with lazy removal. Each transfer on the
// input is a push, a pop, a remove or an unused code that changes nothing; each
// yields exactly one result with the current top, its validity, the live count
// (saturated at 127) and a status. All heap moves go through one
// single-port-per-direction RAM with a registered read, so an item costs a setup
// step plus a sift through the heap levels, repeated for every pending entry
// discarded from the top. Writing cfg_wdata while the queue is idle rebuilds the
// heap in the new order; the input stays not ready until that finishes.
// Pending-removal counts are cleared by reset; no clearing pass is needed.
module lazy_deletion_priority_queue import ldpq_pkg::*; #(
  parameter int HEAP_DEPTH    = HEAP_DEPTH_DEF,
  parameter int PENDING_SLOTS = PENDING_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(HEAP_DEPTH);

  logic             mode_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r;
  logic             out_free;
  logic             resp_valid;
  out_item_t        resp;
  logic             ram_wr_en, ram_rd_en;
  logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
  logic [VAL_W-1:0] ram_wr_data, ram_rd_data;
  pend_cmd_t        pend_cmd;
  pend_stat_t       pend_stat;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (resp_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (resp_valid) begin
      out_r <= resp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ldpq_ctrl #(.HEAP_DEPTH(HEAP_DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .order_mode  (mode_r),
    .cfg_we      (cfg_we),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_data),
    .out_free    (out_free),
    .resp_valid  (resp_valid),
    .resp        (resp),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .pend_cmd    (pend_cmd),
    .pend_stat   (pend_stat)
  );

  ldpq_heap_ram #(.HEAP_DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ldpq_pend_tbl #(.PENDING_SLOTS(PENDING_SLOTS)) u_pend_tbl (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (pend_cmd),
    .stat  (pend_stat)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an item is in progress");
`endif

endmodule

// ===== sim/tb_lazy_deletion_priority_queue.sv =====
`timescale 1ns / 1ps
module tb_lazy_deletion_priority_queue;
  import ldpq_pkg::*;

  localparam int DEPTH = 64;
  localparam int SLOTS = 16;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT = 1200000;
  localparam int DRAIN_CYCLES = 4000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  lazy_deletion_priority_queue DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // queue state mirror
  logic [31:0] heap_q [DEPTH];
  int          heap_n;
  int          live_n;
  logic [31:0] mark_val [SLOTS];
  int          mark_cnt [SLOTS];
  logic        min_top;

  out_item_t   result_q [$];
  logic        check_q [$];   // 1 when a typed-in value is to be compared instead
  out_item_t   typed_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          got = 0;

  // directed table
  typedef struct {
    logic [1:0]  func;
    logic [31:0] value;
    logic        typed;
    out_item_t   want;
  } row_t;

  function automatic logic goes_above(logic [31:0] a, logic [31:0] b);
    return min_top ? ($signed(a) < $signed(b)) : ($signed(a) > $signed(b));
  endfunction

  function automatic void sift_down(int i);
    int l, r, best;
    logic [31:0] t;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      best = i;
      if (l < heap_n && goes_above(heap_q[l], heap_q[best])) best = l;
      if (r < heap_n && goes_above(heap_q[r], heap_q[best])) best = r;
      if (best == i) return;
      t = heap_q[i]; heap_q[i] = heap_q[best]; heap_q[best] = t;
      i = best;
    end
  endfunction

  function automatic void drop_top();
    heap_n--;
    heap_q[0] = heap_q[heap_n];
    sift_down(0);
  endfunction

  function automatic int find_mark(logic [31:0] v);
    for (int k = 0; k < SLOTS; k++)
      if (mark_cnt[k] != 0 && mark_val[k] == v) return k;
    return -1;
  endfunction

  function automatic void discard_marked_top();
    int k;
    while (heap_n > 0) begin
      k = find_mark(heap_q[0]);
      if (k < 0) return;
      mark_cnt[k]--;
      drop_top();
    end
  endfunction

  function automatic void reorder(logic mode);
    min_top = mode;
    for (int i = heap_n / 2; i > 0; i--) sift_down(i - 1);
  endfunction

  function automatic out_item_t apply_op(logic [1:0] func, logic [31:0] v);
    out_item_t r;
    logic [2:0] st;
    int i, p, k;
    logic [31:0] t;
    st = STS_OK;
    if (func == FN_PUSH) begin
      if (heap_n >= DEPTH) st = STS_HEAP_FULL;
      else begin
        i = heap_n++;
        heap_q[i] = v;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!goes_above(heap_q[i], heap_q[p])) break;
          t = heap_q[i]; heap_q[i] = heap_q[p]; heap_q[p] = t;
          i = p;
        end
        live_n++;
      end
    end else if (func == FN_POP) begin
      discard_marked_top();
      if (heap_n == 0 || live_n == 0) st = STS_POP_EMPTY;
      else begin
        drop_top();
        live_n--;
      end
      discard_marked_top();
    end else if (func == FN_REMOVE) begin
      if (live_n == 0) st = STS_REMOVE_ZERO;
      else begin
        k = find_mark(v);
        if (k < 0)
          for (int j = 0; j < SLOTS; j++)
            if (mark_cnt[j] == 0) begin
              k = j;
              break;
            end
        if (k < 0 || mark_cnt[k] >= 127) st = STS_PEND_FULL;
        else begin
          mark_val[k] = v;
          mark_cnt[k]++;
          live_n--;
          discard_marked_top();
        end
      end
    end
    r.top_value = heap_n > 0 ? heap_q[0] : '0;
    r.top_valid = heap_n > 0;
    r.live_count = live_n > 127 ? 7'd127 : live_n[6:0];
    r.status = st;
    return r;
  endfunction

  task automatic report(string what, out_item_t g, out_item_t w);
    errors++;
    $display("mismatch %s at result %0d: got %0d/%0b/%0d/%0d want %0d/%0b/%0d/%0d", what,
             got, g.top_value, g.top_valid, g.live_count, g.status,
             w.top_value, w.top_valid, w.live_count, w.status);
  endtask

  // valid stays up across back-to-back items; it drops only before a gap
  task automatic send(logic [1:0] func, logic [31:0] v, logic typed, out_item_t want);
    out_item_t exp;
    in_item_t it;
    int gap;
    gap = $urandom_range(0, 12) * ($urandom_range(0, 3) != 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.func = func;
    it.value = v;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp = apply_op(func, v);
    result_q = {result_q, exp};
    check_q = {check_q, typed};
    typed_q = {typed_q, want};
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_order(logic mode);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    reorder(mode);
  endtask

  function automatic out_item_t mk(int tv, bit vld, int lc, logic [2:0] st);
    out_item_t r;
    r.top_value = tv;
    r.top_valid = vld;
    r.live_count = lc[6:0];
    r.status = st;
    return r;
  endfunction

  // result side: random stalls, stretches without
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("unexpected result %0d", got);
      end else begin
        out_item_t w;
        logic typed;
        w = result_q.pop_front();
        typed = check_q.pop_front();
        if (typed) begin
          w = typed_q.pop_front();
        end else void'(typed_q.pop_front());
        if (out_data.top_valid !== w.top_valid) report("top_valid", out_data, w);
        else if (w.top_valid && out_data.top_value !== w.top_value)
          report("top_value", out_data, w);
        else if (!w.top_valid && out_data.top_value !== w.top_value)
          report("top_value", out_data, w);
        else if (out_data.live_count !== w.live_count) report("live_count", out_data, w);
        else if (out_data.status !== w.status) report("status", out_data, w);
      end
      got++;
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      stall_left <= (cycles / 5000) % 4 == 0 ? 0 : $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  function automatic logic [31:0] pick_value(int pool);
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $urandom_range(0, pool) - pool / 2;
    endcase
  endfunction

  row_t rows [$];
  out_item_t none;

  function automatic void add_row(logic [1:0] func, logic [31:0] value, logic typed,
                                  out_item_t want);
    row_t row;
    row.func = func;
    row.value = value;
    row.typed = typed;
    row.want = want;
    rows = {rows, row};
  endfunction

  initial begin
    int pool;
    int r;
    none = '0;
    heap_n = 0;
    live_n = 0;
    min_top = 1'b0;
    foreach (mark_cnt[k]) begin
      mark_cnt[k] = 0;
      mark_val[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(FN_POP, 32'd0, 1'b1, mk(0, 0, 0, STS_POP_EMPTY));
    add_row(FN_REMOVE, 32'd5, 1'b1, mk(0, 0, 0, STS_REMOVE_ZERO));
    add_row(2'd3, 32'd9, 1'b1, mk(0, 0, 0, STS_OK));
    add_row(FN_PUSH, 32'h7fffffff, 1'b1, mk(32'h7fffffff, 1, 1, STS_OK));
    add_row(FN_PUSH, 32'h80000000, 1'b1, mk(32'h7fffffff, 1, 2, STS_OK));
    add_row(FN_PUSH, 32'd0, 1'b0, none);
    add_row(FN_PUSH, 32'hffffffff, 1'b0, none);
    add_row(FN_REMOVE, 32'h7fffffff, 1'b0, none);
    add_row(FN_REMOVE, 32'h12345678, 1'b0, none);
    add_row(FN_PUSH, 32'h12345678, 1'b0, none);
    add_row(FN_POP, 32'haaaaaaaa, 1'b0, none);
    add_row(FN_POP, 32'h55555555, 1'b0, none);
    add_row(2'd3, 32'hffffffff, 1'b0, none);
    add_row(FN_POP, 32'd0, 1'b0, none);
    add_row(FN_POP, 32'd0, 1'b0, none);
    foreach (rows[i]) send(rows[i].func, rows[i].value, rows[i].typed, rows[i].want);

    // fill to heap full, then pending table full with distinct marks
    for (int i = 0; i < DEPTH + 2; i++) send(FN_PUSH, $urandom(), 1'b0, none);
    for (int i = 0; i < SLOTS + 2; i++) send(FN_REMOVE, i * 7 - 50, 1'b0, none);
    write_order(1'b1);
    for (int i = 0; i < DEPTH + 2; i++) send(FN_POP, 32'd0, 1'b0, none);
    for (int i = 0; i < SLOTS; i++) send(FN_POP, 32'd0, 1'b0, none);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 400 == 0) write_order(logic'($urandom_range(0, 1)));
      if (i == 800) wait_idle();
      pool = (i / 200) % 2 ? 40 : 8;
      r = $urandom_range(0, 99);
      if (r < 45) send(FN_PUSH, pick_value(pool), 1'b0, none);
      else if (r < 70) send(FN_POP, $urandom(), 1'b0, none);
      else if (r < 97) begin
        // removes mostly target values that are queued
        if (heap_n > 0 && $urandom_range(0, 3) != 0)
          send(FN_REMOVE, heap_q[$urandom_range(0, heap_n - 1)], 1'b0, none);
        else send(FN_REMOVE, pick_value(pool), 1'b0, none);
      end else send(2'd3, $urandom(), 1'b0, none);
    end
    write_order(1'b0);
    for (int i = 0; i < 20; i++) send(FN_POP, 32'd0, 1'b0, none);

    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES / 10) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== lazy_deletion_priority_queue.f =====
design/ldpq_pkg.sv
design/ldpq_heap_ram.sv
design/ldpq_pend_tbl.sv
design/ldpq_ctrl.sv
design/lazy_deletion_priority_queue.sv
sim/tb_lazy_deletion_priority_queue.sv
